// File: rtl/periodic_tick_event_table_defines.svh
// Assertion macros shared by the periodic tick event table RTL.
`ifndef PERIODIC_TICK_EVENT_TABLE_DEFINES_SVH
`define PERIODIC_TICK_EVENT_TABLE_DEFINES_SVH

// Generic clocked assertion with an active-low reset disable.
`define PTET_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

// Assertion on the top-level clock and reset.
`define PTET_ASSERT(lbl, prop, msg) \
    `PTET_ASSERT_CLK(lbl, i_clk, i_rst_n, prop, msg)

`endif

// File: rtl/ptet_pkg.sv
// Types and constants of the periodic tick event table.
package ptet_pkg;

    localparam int MASK_BITS = 8;
    localparam int SLOT_ID_BITS = 3;
    localparam int PERIOD_BITS = 32;

    typedef enum logic [1:0] {
        CMD_TICK      = 2'd0,
        CMD_SET       = 2'd1,
        CMD_CLEAR     = 2'd2,
        CMD_CLEAR_ALL = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd                     cmd;
        logic [PERIOD_BITS-1:0]   period;
        logic [SLOT_ID_BITS-1:0]  slot_sel;
    } t_in_item;

    typedef struct packed {
        logic [MASK_BITS-1:0]     fired_mask;
        logic [SLOT_ID_BITS-1:0]  assigned_slot;
        logic                     table_full;
        logic [MASK_BITS-1:0]     active_mask;
    } t_out_item;

    // Per-cycle command broadcast to every slot cell, already gated by acceptance.
    typedef struct packed {
        logic tick;
        logic set;
        logic clear_all;
    } t_cell_cmd;

endpackage

// File: rtl/ptet_cell.sv
// One slot cell: active flag, reload value and remaining count of a timer slot.
module ptet_cell
    import ptet_pkg::*;
#(
    parameter int COUNT_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cell_cmd             i_cmd,
    input  logic                  i_clear_hit,
    input  logic [COUNT_BITS-1:0] i_period,
    input  logic                  i_claim,
    output logic                  o_claim,
    output logic                  o_take,
    output logic                  o_fired,
    output logic                  o_active_next
);

    logic                  r_active;
    logic                  n_active;
    logic [COUNT_BITS-1:0] r_reload;
    logic [COUNT_BITS-1:0] n_reload;
    logic [COUNT_BITS-1:0] r_remaining;
    logic [COUNT_BITS-1:0] n_remaining;
    logic [COUNT_BITS-1:0] w_dec;
    logic                  w_fire;

    // The claim token passes a busy cell and stops at the first free one.
    assign o_claim = i_claim && r_active;
    assign o_take  = i_cmd.set && i_claim && !r_active;

    assign w_dec   = r_remaining - COUNT_BITS'(1);
    assign w_fire  = i_cmd.tick && r_active && (w_dec == '0);
    assign o_fired = w_fire;

    always_comb begin
        n_active    = r_active;
        n_reload    = r_reload;
        n_remaining = r_remaining;
        if (i_cmd.clear_all || i_clear_hit) begin
            n_active = 1'b0;
        end else if (o_take) begin
            n_active    = 1'b1;
            n_reload    = i_period;
            n_remaining = i_period;
        end else if (i_cmd.tick && r_active) begin
            n_remaining = w_fire ? r_reload : w_dec;
        end
    end

    assign o_active_next = n_active;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else begin
            r_active <= n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        r_reload    <= n_reload;
        r_remaining <= n_remaining;
    end

endmodule

// File: rtl/periodic_tick_event_table.sv
// Periodic tick event table: a row of timer slot cells with a registered result.
//
// Usage: each input transaction carries one command (tick, set, clear, clear all).
// Every accepted command yields exactly one output transaction holding the fired
// mask, the claimed slot or full flag, and the mask of slots active afterwards.
// The result is registered at the edge that accepts the command and shows on
// o_out_valid in the next cycle. Throughput is one command per cycle while the
// output is not stalled; all slot cells update in that same cycle, and the lowest
// free slot for a set is found by a claim token that ripples along the cell chain.
// The output register acts as the boundary between the two sides: a new command
// is taken whenever the register is empty or its result is being taken. When the
// receiver stalls, the result holds and o_in_ready falls until it is taken.
// Reset (synchronous, active low) frees every slot and empties the output
// register; reload and count values are loaded by set and need no reset.
// Only slots 0 to 7 are visible in the 8-bit masks.
`include "periodic_tick_event_table_defines.svh"

module periodic_tick_event_table
    import ptet_pkg::*;
#(
    parameter int SLOT_COUNT = 8,
    parameter int COUNT_BITS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    localparam int MASK_N = (SLOT_COUNT < MASK_BITS) ? SLOT_COUNT : MASK_BITS;

    logic                  w_accept;
    t_cell_cmd             w_cell_cmd;
    logic                  w_clear;
    logic [COUNT_BITS-1:0] w_period;
    logic [SLOT_COUNT:0]   w_claim;
    logic [SLOT_COUNT-1:0] w_take;
    logic [SLOT_COUNT-1:0] w_fired;
    logic [SLOT_COUNT-1:0] w_active_next;
    logic [SLOT_COUNT-1:0] w_clear_hit;
    logic                  w_full;
    t_out_item             w_result;

    logic      r_out_valid;
    logic      n_out_valid;
    t_out_item r_out;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_period   = COUNT_BITS'(i_in_data.period);

    // Command decoder; nothing reaches the cells unless the command is accepted.
    always_comb begin
        w_cell_cmd = '0;
        w_clear    = 1'b0;
        unique case (i_in_data.cmd)
            CMD_TICK:      w_cell_cmd.tick      = w_accept;
            CMD_SET:       w_cell_cmd.set       = w_accept;
            CMD_CLEAR:     w_clear              = w_accept;
            CMD_CLEAR_ALL: w_cell_cmd.clear_all = w_accept;
            default:       w_cell_cmd           = '0;
        endcase
    end

    assign w_claim[0] = 1'b1;

    for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
        if (g < MASK_BITS) begin : g_sel
            assign w_clear_hit[g] = w_clear && (i_in_data.slot_sel == SLOT_ID_BITS'(g));
        end else begin : g_nosel
            assign w_clear_hit[g] = 1'b0;
        end

        ptet_cell #(
            .COUNT_BITS (COUNT_BITS)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_cmd         (w_cell_cmd),
            .i_clear_hit   (w_clear_hit[g]),
            .i_period      (w_period),
            .i_claim       (w_claim[g]),
            .o_claim       (w_claim[g+1]),
            .o_take        (w_take[g]),
            .o_fired       (w_fired[g]),
            .o_active_next (w_active_next[g])
        );
    end

    // A token that leaves the last cell means every slot is busy.
    assign w_full = w_cell_cmd.set && w_claim[SLOT_COUNT];

    always_comb begin
        w_result            = '0;
        w_result.table_full = w_full;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (w_take[i]) begin
                w_result.assigned_slot = w_result.assigned_slot | SLOT_ID_BITS'(i);
            end
        end
        for (int j = 0; j < MASK_N; j++) begin
            w_result.fired_mask[j]  = w_fired[j];
            w_result.active_mask[j] = w_active_next[j];
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_accept) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `PTET_ASSERT(a_take_onehot, $onehot0(w_take), "more than one slot claimed by a set")
    `PTET_ASSERT(a_full_no_take, w_full |-> (w_take == '0), "slot claimed on a full table")
    `PTET_ASSERT(a_result_follows, w_accept |=> o_out_valid, "accepted command gave no result")
    `PTET_ASSERT(a_fired_only_tick,
        (w_accept && (i_in_data.cmd != CMD_TICK)) |=> (o_out_data.fired_mask == '0),
        "fired mask set for a command other than tick")

endmodule
